[src/tdvt_pkg.sv]
// ============================================================================
// tdvt_pkg: shared types and constants for the tolerance dedup vertex table
// Holds the point and code types, the fixed field widths of the channels and
// the configuration register map.
// ============================================================================
package tdvt_pkg;

    // Default table depth; the top level takes it as a parameter.
    localparam int MAX_ENTRIES_DEF = 512;

    // Channel field widths.
    localparam int MODE_W    = 2;
    localparam int COORD_W   = 24;
    localparam int STATUS_W  = 3;
    localparam int OUT_IDX_W = 9;
    localparam int OUT_TOT_W = 10;

    // Match radius and its square.
    localparam int RADIUS_W     = 12;
    localparam int RADIUS_SQ_W  = 2 * RADIUS_W;
    localparam int RADIUS_RESET = 41;

    // Any axis difference of 2**MAG_W or more can never be inside the radius.
    localparam int MAG_W = RADIUS_W;

    // Pipeline depth of the distance unit, from entry data to hit flag.
    localparam int DIST_LAT = 3;

    // Configuration port.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int REG_SEL_W = PADDR_W - 2;
    localparam logic [REG_SEL_W-1:0] REG_MATCH_RADIUS = '0;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } t_point;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD    = 2'd0,
        MODE_LOOKUP = 2'd1,
        MODE_CLEAR  = 2'd2
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_APPENDED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_HIT       = 3'd3,
        ST_MISS      = 3'd4,
        ST_CLEARED   = 3'd5
    } t_status;

endpackage

[src/tdvt_in_if.sv]
// ============================================================================
// tdvt_in_if: request channel of the vertex table
// Carries one request word: the mode and a Q12.12 point.
// ============================================================================
interface tdvt_in_if;
    logic                                   valid;
    logic                                   ready;
    logic [tdvt_pkg::MODE_W-1:0]            mode;
    logic signed [tdvt_pkg::COORD_W-1:0]    x_coord;
    logic signed [tdvt_pkg::COORD_W-1:0]    y_coord;
    logic signed [tdvt_pkg::COORD_W-1:0]    z_coord;

    modport source (output valid, mode, x_coord, y_coord, z_coord, input ready);
    modport sink   (input valid, mode, x_coord, y_coord, z_coord, output ready);
endinterface

[src/tdvt_out_if.sv]
// ============================================================================
// tdvt_out_if: result channel of the vertex table
// Carries one result word: status, entry index and entry total.
// ============================================================================
interface tdvt_out_if;
    logic                               valid;
    logic                               ready;
    logic [tdvt_pkg::STATUS_W-1:0]      status;
    logic [tdvt_pkg::OUT_IDX_W-1:0]     entry_index;
    logic [tdvt_pkg::OUT_TOT_W-1:0]     entry_total;

    modport source (output valid, status, entry_index, entry_total, input ready);
    modport sink   (input valid, status, entry_index, entry_total, output ready);
endinterface

[src/tdvt_apb_regs.sv]
// ============================================================================
// tdvt_apb_regs: configuration registers of the vertex table
// Holds the match radius and keeps its square ready for the distance unit.
// ============================================================================
module tdvt_apb_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tdvt_pkg::PADDR_W-1:0]        paddr,
    input  logic [tdvt_pkg::PDATA_W-1:0]        pwdata,
    output logic [tdvt_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready,
    output logic [tdvt_pkg::RADIUS_SQ_W-1:0]    o_radius_sq
);
    localparam int RADIUS_W    = tdvt_pkg::RADIUS_W;
    localparam int RADIUS_SQ_W = tdvt_pkg::RADIUS_SQ_W;
    localparam int PDATA_W     = tdvt_pkg::PDATA_W;
    localparam int PADDR_W     = tdvt_pkg::PADDR_W;

    logic [RADIUS_W-1:0]    r_radius;
    logic [RADIUS_SQ_W-1:0] r_radius_sq;
    logic [RADIUS_W-1:0]    w_wr_radius;
    logic                   w_sel_radius;

    assign w_sel_radius = (paddr[PADDR_W-1:2] == tdvt_pkg::REG_MATCH_RADIUS);
    assign w_wr_radius  = pwdata[RADIUS_W-1:0];

    // The square is formed once per write, so the scan never multiplies the radius.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius    <= RADIUS_W'(tdvt_pkg::RADIUS_RESET);
            r_radius_sq <= RADIUS_SQ_W'(tdvt_pkg::RADIUS_RESET * tdvt_pkg::RADIUS_RESET);
        end else if (psel && penable && pwrite && w_sel_radius) begin
            r_radius    <= w_wr_radius;
            r_radius_sq <= w_wr_radius * w_wr_radius;
        end
    end

    assign prdata      = w_sel_radius ? PDATA_W'(r_radius) : '0;
    assign pready      = 1'b1;
    assign o_radius_sq = r_radius_sq;
endmodule

[src/tdvt_point_mem.sv]
// ============================================================================
// tdvt_point_mem: point storage of the vertex table
// One write port and one read port with registered read data.
// ============================================================================
module tdvt_point_mem #(
    parameter int DEPTH  = tdvt_pkg::MAX_ENTRIES_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                    i_clk,
    input  logic                    i_wr_en,
    input  logic [ADDR_W-1:0]       i_wr_addr,
    input  tdvt_pkg::t_point        i_wr_data,
    input  logic                    i_rd_en,
    input  logic [ADDR_W-1:0]       i_rd_addr,
    output tdvt_pkg::t_point        o_rd_data
);
    tdvt_pkg::t_point r_mem [DEPTH];
    tdvt_pkg::t_point r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

[src/tdvt_dist_unit.sv]
// ============================================================================
// tdvt_dist_unit: shared distance test of the vertex table
// Three-stage pipeline that tests one stored entry per cycle against the
// query point: squared distance strictly below the squared radius.
// ============================================================================
module tdvt_dist_unit (
    input  logic                                i_clk,
    input  tdvt_pkg::t_point                    i_query,
    input  tdvt_pkg::t_point                    i_entry,
    input  logic [tdvt_pkg::RADIUS_SQ_W-1:0]    i_radius_sq,
    output logic                                o_hit
);
    localparam int COORD_W = tdvt_pkg::COORD_W;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int MAG_W   = tdvt_pkg::MAG_W;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int SUM_W   = SQ_W + 2;

    logic signed [COORD_W-1:0] w_q [3];
    logic signed [COORD_W-1:0] w_e [3];
    logic signed [DIFF_W-1:0]  w_diff [3];
    logic [DIFF_W-1:0]         w_abs [3];
    logic [2:0]                w_far;

    logic [MAG_W-1:0]          r_mag [3];
    logic                      r_far1;
    logic [SQ_W-1:0]           r_sq [3];
    logic                      r_far2;
    logic                      r_hit;
    logic [SUM_W-1:0]          w_sum;

    // Stage 1: per-axis magnitude. A magnitude of 2**MAG_W or more squares to
    // at least the largest possible squared radius, so it can only miss.
    always_comb begin
        w_q[0] = i_query.x;
        w_q[1] = i_query.y;
        w_q[2] = i_query.z;
        w_e[0] = i_entry.x;
        w_e[1] = i_entry.y;
        w_e[2] = i_entry.z;
        for (int a = 0; a < 3; a++) begin
            w_diff[a] = DIFF_W'(w_q[a]) - DIFF_W'(w_e[a]);
            w_abs[a]  = w_diff[a][DIFF_W-1] ? DIFF_W'(-w_diff[a]) : DIFF_W'(w_diff[a]);
            w_far[a]  = |w_abs[a][DIFF_W-1:MAG_W];
        end
    end

    assign w_sum = SUM_W'(r_sq[0]) + SUM_W'(r_sq[1]) + SUM_W'(r_sq[2]);

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 3; a++) begin
            r_mag[a] <= w_abs[a][MAG_W-1:0];
            r_sq[a]  <= r_mag[a] * r_mag[a];
        end
        r_far1 <= |w_far;
        r_far2 <= r_far1;
        r_hit  <= !r_far2 && (w_sum < SUM_W'(i_radius_sq));
    end

    assign o_hit = r_hit;
endmodule

[src/tolerance_dedup_vertex_table_core.sv]
// ============================================================================
// tolerance_dedup_vertex_table_core: tolerance-based deduplicating point table
// Stores Q12.12 points, merges points that fall within the match radius of a
// stored one, and answers lookups with the lowest matching index.
// ============================================================================
// Usage:
//   Requests arrive as words on i_in (mode plus an x/y/z point). Each accepted
//   request with mode add, lookup or clear yields exactly one word on o_out
//   (status, entry index, entry total); mode 3 is taken and yields nothing.
//   The match radius is written through the APB-style port at address 0.
//   Write it only while the table is idle; the block does not enforce this.
//   Add and lookup scan the stored entries in order, one entry per cycle,
//   through the single read port of the point memory and a three-stage
//   distance unit; a match ends the scan at its index. Clear, a full-table
//   add and a request on an empty table need no scan.
//   i_in.ready is high only while no request is in flight and reset is
//   released. A finished result sits in the output register; the next
//   request is accepted while it waits, and that request's own result is
//   held until the receiver has taken it.
//   Reset empties the table and restores the radius to 41 (0.01 in Q12.12).
//   The point memory is not cleared; only entries below the count are read.
// ============================================================================
module tolerance_dedup_vertex_table_core #(
    parameter int MAX_ENTRIES = tdvt_pkg::MAX_ENTRIES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    tdvt_in_if.sink                         i_in,
    tdvt_out_if.source                      o_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tdvt_pkg::PADDR_W-1:0]    paddr,
    input  logic [tdvt_pkg::PDATA_W-1:0]    pwdata,
    output logic [tdvt_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready
);
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int TAG_DEPTH   = tdvt_pkg::DIST_LAT + 1;
    localparam int OUT_IDX_W   = tdvt_pkg::OUT_IDX_W;
    localparam int OUT_TOT_W   = tdvt_pkg::OUT_TOT_W;
    localparam int RADIUS_SQ_W = tdvt_pkg::RADIUS_SQ_W;

    // Travels alongside each entry read so that the hit flag can be matched
    // back to its index once it leaves the distance unit.
    typedef struct packed {
        logic             vld;
        logic             last;
        logic [IDX_W-1:0] idx;
    } t_tag;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state                 r_state;
    tdvt_pkg::t_mode        r_mode;
    tdvt_pkg::t_point       r_pt;
    logic [CNT_W-1:0]       r_count;
    logic [IDX_W-1:0]       r_rd_idx;
    logic                   r_issuing;
    t_tag                   r_tag [TAG_DEPTH];

    tdvt_pkg::t_status      r_res_status;
    logic [IDX_W-1:0]       r_res_idx;
    logic [CNT_W-1:0]       r_res_total;

    logic                       r_out_valid;
    logic [tdvt_pkg::STATUS_W-1:0] r_out_status;
    logic [OUT_IDX_W-1:0]       r_out_idx;
    logic [OUT_TOT_W-1:0]       r_out_total;

    tdvt_pkg::t_point       w_in_pt;
    tdvt_pkg::t_point       w_rd_pt;
    tdvt_pkg::t_point       w_wr_pt;
    logic                   w_wr_en;
    logic [IDX_W-1:0]       w_wr_addr;
    logic                   w_accept;
    logic                   w_hit;
    logic                   w_fin;
    logic                   w_out_free;
    logic [IDX_W-1:0]       w_last_idx;
    logic [RADIUS_SQ_W-1:0] w_radius_sq;
    logic                   w_empty_append;
    logic                   w_scan_append;

    // ------------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------------
    tdvt_apb_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_radius_sq (w_radius_sq)
    );

    // ------------------------------------------------------------------------
    // Point memory and the shared distance unit.
    // ------------------------------------------------------------------------
    tdvt_point_mem #(
        .DEPTH  (MAX_ENTRIES),
        .ADDR_W (IDX_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_pt),
        .i_rd_en   (r_issuing),
        .i_rd_addr (r_rd_idx),
        .o_rd_data (w_rd_pt)
    );

    tdvt_dist_unit u_dist (
        .i_clk       (i_clk),
        .i_query     (r_pt),
        .i_entry     (w_rd_pt),
        .i_radius_sq (w_radius_sq),
        .o_hit       (w_hit)
    );

    // ------------------------------------------------------------------------
    // Handshake and write-side decode.
    // ------------------------------------------------------------------------
    always_comb begin
        w_in_pt.x = i_in.x_coord;
        w_in_pt.y = i_in.y_coord;
        w_in_pt.z = i_in.z_coord;
    end

    assign i_in.ready  = (r_state == S_IDLE) && i_rst_n;
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_out_free  = !r_out_valid || o_out.ready;
    assign w_last_idx  = IDX_W'(r_count - CNT_W'(1));
    assign w_fin       = r_tag[TAG_DEPTH-1].vld;

    // An add to an empty table needs no scan and is written straight away.
    // Otherwise a point is appended when the scan of an add finds no match.
    assign w_empty_append = w_accept && (i_in.mode == tdvt_pkg::MODE_ADD)
                            && (r_count == '0);
    assign w_scan_append  = (r_state == S_SCAN) && w_fin && !w_hit
                            && r_tag[TAG_DEPTH-1].last && (r_mode == tdvt_pkg::MODE_ADD);
    assign w_wr_en        = w_empty_append || w_scan_append;
    assign w_wr_addr      = IDX_W'(r_count);
    assign w_wr_pt        = (r_state == S_IDLE) ? w_in_pt : r_pt;

    // ------------------------------------------------------------------------
    // Sequencer: issues one entry read per cycle, retires the tag stream and
    // forms the result word.
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_issuing   <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < TAG_DEPTH; i++) begin
                r_tag[i].vld <= 1'b0;
            end
        end else begin
            if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            r_tag[0].vld  <= r_issuing;
            r_tag[0].last <= (r_rd_idx == w_last_idx);
            r_tag[0].idx  <= r_rd_idx;
            for (int i = 1; i < TAG_DEPTH; i++) begin
                r_tag[i] <= r_tag[i-1];
            end

            if (r_issuing) begin
                r_rd_idx <= r_rd_idx + IDX_W'(1);
                if (r_rd_idx == w_last_idx) begin
                    r_issuing <= 1'b0;
                end
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_pt        <= w_in_pt;
                        r_mode      <= tdvt_pkg::t_mode'(i_in.mode);
                        r_res_idx   <= '0;
                        r_res_total <= r_count;
                        case (tdvt_pkg::t_mode'(i_in.mode))
                            tdvt_pkg::MODE_ADD: begin
                                if (r_count >= CNT_W'(MAX_ENTRIES)) begin
                                    r_res_status <= tdvt_pkg::ST_FULL;
                                    r_state      <= S_DONE;
                                end else if (r_count == '0) begin
                                    r_res_status <= tdvt_pkg::ST_APPENDED;
                                    r_count      <= CNT_W'(1);
                                    r_res_total  <= CNT_W'(1);
                                    r_state      <= S_DONE;
                                end else begin
                                    r_rd_idx  <= '0;
                                    r_issuing <= 1'b1;
                                    r_state   <= S_SCAN;
                                end
                            end
                            tdvt_pkg::MODE_LOOKUP: begin
                                if (r_count == '0) begin
                                    r_res_status <= tdvt_pkg::ST_MISS;
                                    r_state      <= S_DONE;
                                end else begin
                                    r_rd_idx  <= '0;
                                    r_issuing <= 1'b1;
                                    r_state   <= S_SCAN;
                                end
                            end
                            tdvt_pkg::MODE_CLEAR: begin
                                r_count      <= '0;
                                r_res_total  <= '0;
                                r_res_status <= tdvt_pkg::ST_CLEARED;
                                r_state      <= S_DONE;
                            end
                            default: begin
                                // The unused mode is consumed without a result.
                            end
                        endcase
                    end
                end

                S_SCAN: begin
                    // Tags retire in index order, so the first hit is the
                    // lowest matching index; later reads are discarded.
                    if (w_fin && (w_hit || r_tag[TAG_DEPTH-1].last)) begin
                        r_state   <= S_DONE;
                        r_issuing <= 1'b0;
                        for (int i = 0; i < TAG_DEPTH; i++) begin
                            r_tag[i].vld <= 1'b0;
                        end
                        if (w_hit) begin
                            r_res_idx    <= r_tag[TAG_DEPTH-1].idx;
                            r_res_status <= (r_mode == tdvt_pkg::MODE_ADD) ?
                                            tdvt_pkg::ST_DUPLICATE : tdvt_pkg::ST_HIT;
                        end else if (r_mode == tdvt_pkg::MODE_ADD) begin
                            r_res_idx    <= IDX_W'(r_count);
                            r_res_status <= tdvt_pkg::ST_APPENDED;
                            r_count      <= r_count + CNT_W'(1);
                            r_res_total  <= r_count + CNT_W'(1);
                        end else begin
                            r_res_status <= tdvt_pkg::ST_MISS;
                        end
                    end
                end

                S_DONE: begin
                    if (w_out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_res_status;
                        r_out_idx    <= OUT_IDX_W'(r_res_idx);
                        r_out_total  <= OUT_TOT_W'(r_res_total);
                        r_state      <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_out_status;
    assign o_out.entry_index = r_out_idx;
    assign o_out.entry_total = r_out_total;

    // ------------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------------
    a_append_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("append did not advance the entry count by one");

    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tag[0].vld |-> (CNT_W'(r_tag[0].idx) < r_count))
        else $error("scan read an entry at or beyond the entry count");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_in.mode == tdvt_pkg::MODE_CLEAR))
        |=> (r_count == '0) && (r_state == S_DONE))
        else $error("clear did not empty the table");

    a_no_stray_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_SCAN) |-> !r_issuing)
        else $error("entry reads issued outside a scan");
endmodule

[tb/tdvt_checker.sv]
`timescale 1ns / 1ps
// ============================================================================
// tdvt_checker: reply predictor and scoreboard for the vertex table
// Watches the request, reply and register channels. Keeps its own copy of
// the point table and the match radius, predicts the reply word of every
// accepted request and compares each reply word with the oldest prediction.
// ============================================================================
module tdvt_checker #(
    parameter int TABLE_DEPTH = tdvt_pkg::MAX_ENTRIES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    tdvt_in_if                              i_req,
    tdvt_out_if                             i_rsp,
    input  logic                            i_psel,
    input  logic                            i_penable,
    input  logic                            i_pwrite,
    input  logic                            i_pready,
    input  logic [tdvt_pkg::PADDR_W-1:0]    i_paddr,
    input  logic [tdvt_pkg::PDATA_W-1:0]    i_pwdata,
    output int                              o_fail_count,
    output int                              o_pending
);
    import tdvt_pkg::*;

    typedef struct packed {
        t_status                status;
        logic [OUT_IDX_W-1:0]   index;
        logic [OUT_TOT_W-1:0]   total;
    } t_reply;

    t_point                 stored_points [TABLE_DEPTH];
    int unsigned            stored_count;
    logic [RADIUS_W-1:0]    radius_q;
    t_reply                 expected_replies [$];
    int                     mismatch_total = 0;
    int unsigned            reply_no;

    assign o_fail_count = mismatch_total;

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatch_total++;
    endtask

    function automatic longint sq_axis(input logic signed [COORD_W-1:0] a,
                                       input logic signed [COORD_W-1:0] b);
        longint d;
        d = longint'(a) - longint'(b);
        return d * d;
    endfunction

    // Lowest stored index strictly inside the radius, or -1.
    function automatic int find_lowest_match(input t_point p);
        longint r2;
        longint d2;
        r2 = longint'(radius_q) * longint'(radius_q);
        for (int i = 0; i < int'(stored_count); i++) begin
            d2 = sq_axis(p.x, stored_points[i].x) + sq_axis(p.y, stored_points[i].y)
               + sq_axis(p.z, stored_points[i].z);
            if (d2 < r2) return i;
        end
        return -1;
    endfunction

    function automatic t_reply predict_table_reply(input t_mode mode, input t_point p);
        t_reply r;
        int     hit;
        r.status = ST_CLEARED;
        r.index  = '0;
        case (mode)
            MODE_ADD: begin
                // A full table drops the point without searching.
                if (stored_count >= TABLE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    hit = find_lowest_match(p);
                    if (hit >= 0) begin
                        r.status = ST_DUPLICATE;
                        r.index  = hit[OUT_IDX_W-1:0];
                    end else begin
                        stored_points[stored_count] = p;
                        r.index  = stored_count[OUT_IDX_W-1:0];
                        stored_count++;
                        r.status = ST_APPENDED;
                    end
                end
            end
            MODE_LOOKUP: begin
                hit = find_lowest_match(p);
                if (hit >= 0) begin
                    r.status = ST_HIT;
                    r.index  = hit[OUT_IDX_W-1:0];
                end else begin
                    r.status = ST_MISS;
                end
            end
            default: begin
                stored_count = 0;
            end
        endcase
        r.total = stored_count[OUT_TOT_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_reply got;
        t_reply want;
        t_point p;
        if (!i_rst_n) begin
            stored_count = 0;
            radius_q     = RADIUS_W'(RADIUS_RESET);
            expected_replies.delete();
            reply_no     = 0;
            o_pending   <= 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready
                && i_paddr[PADDR_W-1:2] == REG_MATCH_RADIUS) begin
                radius_q = i_pwdata[RADIUS_W-1:0];
            end

            // Retire the reply first, so a stray reply never pairs with a
            // request taken at the same edge.
            if (i_rsp.valid && i_rsp.ready) begin
                got.status = t_status'(i_rsp.status);
                got.index  = i_rsp.entry_index;
                got.total  = i_rsp.entry_total;
                if (expected_replies.size() == 0) begin
                    report_mismatch($sformatf(
                        "reply %0d with none expected: status %0d index %0d total %0d",
                        reply_no, got.status, got.index, got.total));
                end else begin
                    want = expected_replies.pop_front();
                    if (got.status !== want.status)
                        report_mismatch($sformatf("reply %0d status %0d, expected %0d",
                                                  reply_no, got.status, want.status));
                    if (got.index !== want.index)
                        report_mismatch($sformatf("reply %0d entry_index %0d, expected %0d",
                                                  reply_no, got.index, want.index));
                    if (got.total !== want.total)
                        report_mismatch($sformatf("reply %0d entry_total %0d, expected %0d",
                                                  reply_no, got.total, want.total));
                end
                reply_no++;
            end

            if (i_req.valid && i_req.ready
                && (i_req.mode == MODE_ADD || i_req.mode == MODE_LOOKUP
                    || i_req.mode == MODE_CLEAR)) begin
                p.x = i_req.x_coord;
                p.y = i_req.y_coord;
                p.z = i_req.z_coord;
                expected_replies.push_back(predict_table_reply(t_mode'(i_req.mode), p));
            end
            o_pending <= expected_replies.size();
        end
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb: top of the vertex table testbench
// Drives request words with bursty timing, stalls the reply channel on its
// own pattern, rewrites the match radius between phases and gives the
// verdict from the failure count of the checker.
// ============================================================================
module tb;
    import tdvt_pkg::*;

    localparam int TABLE_DEPTH = MAX_ENTRIES_DEF;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int COORD_MIN   = -(1 << (COORD_W - 1));
    localparam int COORD_MAX   = (1 << (COORD_W - 1)) - 1;
    localparam int RADIUS_MAX  = (1 << RADIUS_W) - 1;
    // Spacing of the fill pattern: one slot of the x axis per table entry, so
    // no two filled points can ever lie within the largest radius.
    localparam int GRID_STEP   = (1 << COORD_W) / TABLE_DEPTH;
    // Quiet cycles allowed once the last reply is in, before a register write
    // and at the end. A mode 3 request makes no reply, so this also covers it.
    localparam int IDLE_GUARD  = 32;
    // Longest stretch with no handshake at all; it must cover a full-table scan
    // and a choked receiver.
    localparam int STALL_LIMIT = 20000;
    localparam int POOL_DEPTH  = 48;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        t_point             pt;
    } t_request;

    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_JITTER,
        SINK_PERIODIC,
        SINK_CHOKED
    } t_sink_style;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               sink_ready = 1'b0;

    int                 mismatch_count;
    int                 pending_replies;
    int                 quiet_cycles;
    int                 burst_left = 0;
    int unsigned        radius_now = RADIUS_RESET;
    t_point             recent_points [$];

    t_sink_style        sink_style;
    int unsigned        style_left;
    int unsigned        sink_phase;

    tdvt_in_if  req_if ();
    tdvt_out_if rsp_if ();

    assign rsp_if.ready = sink_ready;

    always #4 clk = ~clk;

    tolerance_dedup_vertex_table_core #(
        .MAX_ENTRIES(TABLE_DEPTH)
    ) uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (req_if),
        .o_out   (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    tdvt_checker #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req        (req_if),
        .i_rsp        (rsp_if),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (mismatch_count),
        .o_pending    (pending_replies)
    );

    // ------------------------------------------------------------------------
    // Reply channel: the receiver switches between four stall styles, each held
    // for a random stretch. Open stretches let the block run back to back, the
    // others leave a finished word waiting while the next request is taken.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            sink_ready <= 1'b0;
            sink_style <= SINK_OPEN;
            style_left <= 0;
            sink_phase <= 0;
        end else begin
            sink_phase <= sink_phase + 1;
            if (style_left == 0) begin
                sink_style <= t_sink_style'($urandom_range(0, 3));
                style_left <= $urandom_range(40, 400);
            end else begin
                style_left <= style_left - 1;
            end
            case (sink_style)
                SINK_OPEN:     sink_ready <= 1'b1;
                SINK_JITTER:   sink_ready <= ($urandom_range(0, 9) < 7);
                SINK_PERIODIC: sink_ready <= (sink_phase % 5 < 2);
                default:       sink_ready <= ($urandom_range(0, 15) == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: any handshake on either channel or any register access keeps
    // it quiet. A hang ends the run as a failure.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
            || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [COORD_W-1:0] to_coord(input int v);
        return v[COORD_W-1:0];
    endfunction

    function automatic t_request make_request(input logic [MODE_W-1:0] mode,
                                              input int x, input int y, input int z);
        t_request rq;
        rq.mode = mode;
        rq.pt.x = to_coord(x);
        rq.pt.y = to_coord(y);
        rq.pt.z = to_coord(z);
        return rq;
    endfunction

    // A point whose every axis is within span of the base point, wrapping at
    // the edges of the coordinate range.
    function automatic t_point point_near(input t_point base, input int unsigned span);
        t_point q;
        int     dx;
        int     dy;
        int     dz;
        dx = int'($urandom_range(0, 2 * span)) - int'(span);
        dy = int'($urandom_range(0, 2 * span)) - int'(span);
        dz = int'($urandom_range(0, 2 * span)) - int'(span);
        q.x = base.x + to_coord(dx);
        q.y = base.y + to_coord(dy);
        q.z = base.z + to_coord(dz);
        return q;
    endfunction

    function automatic logic [COORD_W-1:0] any_coord();
        logic [31:0] r;
        r = $urandom();
        return r[COORD_W-1:0];
    endfunction

    // Random requests are built so that 45 in 100 of them land near or on points
    // that were added recently: that is where duplicates and lowest-index hits
    // come from. Clustered small coordinates collide among themselves, and
    // full-range coordinates exercise every bit and the far-miss path.
    function automatic t_request make_random_request();
        t_request    rq;
        int unsigned roll;
        int unsigned span;
        int          lim;
        span = radius_now + 3;
        lim  = 2 * int'(span);
        roll = $urandom_range(0, 99);
        if (roll < 58)      rq.mode = MODE_ADD;
        else if (roll < 93) rq.mode = MODE_LOOKUP;
        else if (roll < 96) rq.mode = MODE_CLEAR;
        else                rq.mode = MODE_UNUSED;

        roll = $urandom_range(0, 99);
        if (roll < 35 && recent_points.size() > 0) begin
            rq.pt = point_near(recent_points[$urandom_range(0, recent_points.size() - 1)],
                               span);
        end else if (roll < 45 && recent_points.size() > 0) begin
            rq.pt = recent_points[$urandom_range(0, recent_points.size() - 1)];
        end else if (roll < 60) begin
            rq.pt.x = to_coord(int'($urandom_range(0, 2 * lim)) - lim);
            rq.pt.y = to_coord(int'($urandom_range(0, 2 * lim)) - lim);
            rq.pt.z = to_coord(int'($urandom_range(0, 2 * lim)) - lim);
        end else begin
            rq.pt.x = any_coord();
            rq.pt.y = any_coord();
            rq.pt.z = any_coord();
        end

        if (rq.mode == MODE_ADD) begin
            recent_points.push_back(rq.pt);
            if (recent_points.size() > POOL_DEPTH) void'(recent_points.pop_front());
        end
        return rq;
    endfunction

    // Bursts of random length separated by gaps of random length.
    function automatic int next_gap();
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        burst_left = $urandom_range(1, 24);
        return ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
    endfunction

    // Presents one request word and returns at the edge where it is taken.
    // Valid stays high afterwards, so a word that follows in the same burst
    // goes out with no idle cycle in between.
    task automatic send_request(input t_request rq);
        int gap;
        gap = next_gap();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid   <= 1'b1;
        req_if.mode    <= rq.mode;
        req_if.x_coord <= rq.pt.x;
        req_if.y_coord <= rq.pt.y;
        req_if.z_coord <= rq.pt.z;
        do @(posedge clk); while (!req_if.ready);
    endtask

    // Stops the request stream and waits until every reply has come back,
    // then a little longer for any request that makes no reply.
    task automatic wait_idle();
        req_if.valid <= 1'b0;
        do @(posedge clk); while (pending_replies != 0);
        repeat (IDLE_GUARD) @(posedge clk);
    endtask

    // Register write: setup cycle, then access cycle until pready. The upper
    // data bits are random and must be ignored by the block.
    task automatic set_radius(input int unsigned r);
        logic [PDATA_W-1:0] word;
        word = $urandom();
        word[RADIUS_W-1:0] = r[RADIUS_W-1:0];
        radius_now = r;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_MATCH_RADIUS, 2'b00};
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Directed part, run with the reset radius of 41. The squared radius is
    // 1681, so a diagonal offset of 23 on every axis (1587) matches and one of
    // 24 (1728) does not, and an offset of exactly 41 on one axis does not.
    task automatic run_directed();
        // Clear and lookup on an empty table.
        send_request(make_request(MODE_CLEAR, 0, 0, 0));
        send_request(make_request(MODE_LOOKUP, 0, 0, 0));
        // Both corners of the coordinate cube; their distance is the largest
        // there is, so the squares must not overflow.
        send_request(make_request(MODE_ADD, COORD_MIN, COORD_MIN, COORD_MIN));
        send_request(make_request(MODE_ADD, COORD_MAX, COORD_MAX, COORD_MAX));
        send_request(make_request(MODE_ADD, COORD_MIN + 40, COORD_MIN, COORD_MIN));
        // Exactly on the radius is not a match.
        send_request(make_request(MODE_ADD, COORD_MAX, COORD_MAX - 41, COORD_MAX));
        send_request(make_request(MODE_ADD, 0, 0, 0));
        send_request(make_request(MODE_ADD, 23, 23, 23));
        send_request(make_request(MODE_ADD, 24, -24, 24));
        // Two entries in range: the lower index must win.
        send_request(make_request(MODE_LOOKUP, 12, -12, 12));
        send_request(make_request(MODE_LOOKUP, COORD_MAX, COORD_MAX - 20, COORD_MAX));
        // Alternating bit patterns.
        send_request(make_request(MODE_LOOKUP, 'h555555, 'hAAAAAA, 'h555555));
        send_request(make_request(MODE_ADD, 'h555555, 'hAAAAAA, 'h555555));
        send_request(make_request(MODE_ADD, 'hAAAAAA, 'h555555, 'hAAAAAA));
        // The unused mode is taken and makes no reply.
        send_request(make_request(MODE_UNUSED, 0, 0, 0));
        send_request(make_request(MODE_LOOKUP, 'h555555, 'hAAAAAA, 'h555555));
        send_request(make_request(MODE_ADD, COORD_MIN, COORD_MAX, COORD_MIN));
        // After a clear the old entries are stale and must not be seen.
        send_request(make_request(MODE_CLEAR, COORD_MAX, COORD_MIN, COORD_MAX));
        send_request(make_request(MODE_LOOKUP, 0, 0, 0));
        send_request(make_request(MODE_ADD, -1, -1, -1));
        send_request(make_request(MODE_LOOKUP, 40, -1, -1));
        send_request(make_request(MODE_LOOKUP, 38, -1, -1));
    endtask

    // Fills the table to capacity with points that can never match each
    // other, mixed with hits and duplicates on points already stored. Once
    // full, an add is dropped even when it is an exact copy of an entry.
    task automatic fill_table();
        t_point      grid [$];
        t_point      p;
        int unsigned span;
        span = radius_now / 2;
        send_request(make_request(MODE_CLEAR, 0, 0, 0));
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            p.x = to_coord(COORD_MIN + i * GRID_STEP + int'($urandom_range(0, 4095)));
            p.y = any_coord();
            p.z = any_coord();
            grid.push_back(p);
            send_request('{mode: MODE_ADD, pt: p});
            if ($urandom_range(0, 7) == 0) begin
                p = point_near(grid[$urandom_range(0, grid.size() - 1)], span);
                send_request('{mode: ($urandom_range(0, 1) == 0) ? MODE_ADD : MODE_LOOKUP,
                               pt: p});
            end
        end
        p.x = any_coord();
        p.y = any_coord();
        p.z = any_coord();
        send_request('{mode: MODE_ADD, pt: p});
        send_request('{mode: MODE_ADD, pt: grid[0]});
        send_request('{mode: MODE_LOOKUP, pt: point_near(grid[TABLE_DEPTH - 1], span)});
        send_request('{mode: MODE_LOOKUP, pt: p});
        send_request('{mode: MODE_UNUSED, pt: p});
        send_request(make_request(MODE_CLEAR, 0, 0, 0));
        send_request('{mode: MODE_ADD, pt: grid[TABLE_DEPTH - 1]});
    endtask

    // ------------------------------------------------------------------------
    // Run sequence. The radius starts at its reset value, then goes to zero
    // (nothing matches), to the largest value, to a random middle value, to a
    // small value, and finally to a random value for the full-table phase.
    // The register is only written once the block is idle.
    // ------------------------------------------------------------------------
    initial begin
        req_if.valid   <= 1'b0;
        req_if.mode    <= MODE_ADD;
        req_if.x_coord <= '0;
        req_if.y_coord <= '0;
        req_if.z_coord <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        wait_idle();

        // With a zero radius an exact repeat is still a new entry.
        set_radius(0);
        send_request(make_request(MODE_ADD, 100, -200, 300));
        send_request(make_request(MODE_ADD, 100, -200, 300));
        send_request(make_request(MODE_LOOKUP, 100, -200, 300));
        repeat (60) send_request(make_random_request());
        wait_idle();

        set_radius(RADIUS_MAX);
        repeat (150) send_request(make_random_request());
        wait_idle();

        set_radius($urandom_range(2, RADIUS_MAX - 1));
        repeat (180) send_request(make_random_request());
        wait_idle();

        set_radius($urandom_range(1, 64));
        repeat (180) send_request(make_random_request());
        wait_idle();

        set_radius($urandom_range(64, RADIUS_MAX));
        fill_table();
        wait_idle();

        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
